[rtl/rtba_pkg.sv]
package rtba_pkg;

    localparam int STORE_BYTES_DEF = 4096;
    localparam int MAX_FIELDS_DEF  = 16;

    typedef enum logic [2:0] {
        ACT_ADD_FIELD  = 3'd0,
        ACT_CLEAR      = 3'd1,
        ACT_LOAD_BYTE  = 3'd2,
        ACT_GET_BITS   = 3'd3,
        ACT_SET_BITS   = 3'd4,
        ACT_GET_WORD   = 3'd5,
        ACT_SET_WORD   = 3'd6,
        ACT_NOP        = 3'd7
    } act_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIELD = 2'd1,
        ST_RANGE   = 2'd2,
        ST_FULL    = 2'd3
    } st_t;

    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_ENTRY_SIZE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_MUL,
        S_ADD,
        S_CHECK,
        S_ACCESS,
        S_DONE
    } state_t;

    typedef struct packed {
        act_t        action;
        logic [31:0] field_key;
        logic [31:0] field_mask;
        logic [15:0] field_start;
        logic [4:0]  field_shift;
        logic [15:0] rec_index;
        logic [11:0] byte_offset;
        logic [7:0]  byte_value;
        logic [31:0] write_value;
    } item_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] mask;
        logic [15:0] start;
        logic [4:0]  shift;
    } desc_t;

    typedef struct packed {
        logic item_load;
        logic desc_add;
        logic desc_clear;
        logic byte_load;
        logic scan_clr;
        logic scan_rd;
        logic scan_inc;
        logic do_mul;
        logic do_add;
        logic store_rd;
        logic store_wr;
        logic rd_capture;
        logic st_set;
        st_t  st_code;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        act_t action;
        logic full;
        logic boff_ok;
        logic scan_end;
        logic key_match;
        logic in_range;
        logic res_busy;
    } sts_t;

endpackage

[rtl/rtba_in_if.sv]
interface rtba_in_if import rtba_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] field_key;
    logic [31:0] field_mask;
    logic [15:0] field_start;
    logic [4:0]  field_shift;
    logic [15:0] rec_index;
    logic [11:0] byte_offset;
    logic [7:0]  byte_value;
    logic [31:0] write_value;

    modport source (output valid, action, field_key, field_mask, field_start, field_shift,
                    rec_index, byte_offset, byte_value, write_value, input ready);
    modport sink (input valid, action, field_key, field_mask, field_start, field_shift,
                  rec_index, byte_offset, byte_value, write_value, output ready);
endinterface

[rtl/rtba_out_if.sv]
interface rtba_out_if import rtba_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] read_value;
    logic [1:0]  status;

    modport source (output valid, read_value, status, input ready);
    modport sink (input valid, read_value, status, output ready);
endinterface

[rtl/rtba_ram.sv]
module rtba_ram #(
    parameter int W = 8,
    parameter int D = 1024
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
    input  logic [W-1:0]                      wdata,
    input  logic                              re,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
    output logic [W-1:0]                      rdata
);
    logic [W-1:0] mem_reg [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/rtba_ctrl.sv]
module rtba_ctrl import rtba_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.action) inside
                    ACT_GET_BITS, ACT_SET_BITS, ACT_GET_WORD, ACT_SET_WORD:
                        state_next = S_SCAN_RD;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_SCAN_RD:  state_next = sts.scan_end ? S_DONE : S_SCAN_CMP;
            S_SCAN_CMP: state_next = sts.key_match ? S_MUL : S_SCAN_RD;
            S_MUL:      state_next = S_ADD;
            S_ADD:      state_next = S_CHECK;
            S_CHECK:    state_next = sts.in_range ? S_ACCESS : S_DONE;
            S_ACCESS:   state_next = S_DONE;
            S_DONE:
            begin
                if (!sts.res_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.st_code = ST_OK;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.item_load = in_valid;
            end
            S_DISPATCH:
            begin
                unique case (sts.action)
                    ACT_ADD_FIELD:
                    begin
                        if (sts.full)
                        begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.desc_add = 1'b1;
                        end
                    end
                    ACT_CLEAR: cmd.desc_clear = 1'b1;
                    ACT_LOAD_BYTE:
                    begin
                        if (sts.boff_ok)
                        begin
                            cmd.byte_load = 1'b1;
                        end
                        else
                        begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_RANGE;
                        end
                    end
                    ACT_GET_BITS, ACT_SET_BITS, ACT_GET_WORD, ACT_SET_WORD:
                        cmd.scan_clr = 1'b1;
                    default: ;
                endcase
            end
            S_SCAN_RD:
            begin
                if (sts.scan_end)
                begin
                    cmd.st_set  = 1'b1;
                    cmd.st_code = ST_NOFIELD;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                end
            end
            S_SCAN_CMP: cmd.scan_inc = !sts.key_match;
            S_MUL:      cmd.do_mul = 1'b1;
            S_ADD:      cmd.do_add = 1'b1;
            S_CHECK:
            begin
                if (sts.in_range)
                begin
                    cmd.store_rd = 1'b1;
                end
                else
                begin
                    cmd.st_set  = 1'b1;
                    cmd.st_code = ST_RANGE;
                end
            end
            S_ACCESS:
            begin
                if (sts.action == ACT_SET_BITS || sts.action == ACT_SET_WORD)
                begin
                    cmd.store_wr = 1'b1;
                end
                else
                begin
                    cmd.rd_capture = 1'b1;
                end
            end
            S_DONE:     cmd.res_load = !sts.res_busy;
            default: ;
        endcase
    end
endmodule

[rtl/rtba_dp.sv]
module rtba_dp import rtba_pkg::*; #(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int MAX_FIELDS  = MAX_FIELDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_value,
    output logic [1:0]  status
);
    localparam int AW = $clog2(STORE_BYTES);
    localparam int BD = (STORE_BYTES + 3) / 4;
    localparam int RW = $clog2(BD);
    localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int CW = $clog2(MAX_FIELDS + 1);

    item_t        item_reg;
    logic [15:0]  entry_count_reg;
    logic [12:0]  entry_size_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] scan_reg;
    logic [28:0]  prod_reg;
    logic [28:0]  table_reg;
    logic [AW-1:0] off_reg;
    logic         in_range_reg;
    logic [31:0]  rd_reg;
    st_t          st_reg;
    logic         res_valid_reg;
    logic [31:0]  res_value_reg;
    st_t          res_status_reg;

    desc_t        desc_wdata;
    desc_t        desc_rd;
    logic [$bits(desc_t)-1:0] desc_rdata;

    logic [29:0]  off_sum;
    logic [30:0]  off_end;
    logic [16:0]  boff_ext;
    logic [AW-1:0] boff_a;
    logic [31:0]  word;
    logic [31:0]  new_word;
    logic [7:0]   bank_rd [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            entry_size_reg  <= '0;
            count_reg       <= '0;
            scan_reg        <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ENTRY_COUNT: entry_count_reg <= cfg_data;
                    CFG_ENTRY_SIZE:  entry_size_reg  <= cfg_data[12:0];
                    default: ;
                endcase
            end
            if (cmd.desc_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.desc_add)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.scan_clr)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign off_sum = {1'b0, prod_reg} + 30'(desc_rd.start);
    assign off_end = {1'b0, off_sum} + 31'd4;

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= item;
            rd_reg   <= '0;
            st_reg   <= ST_OK;
        end
        if (cmd.st_set)
        begin
            st_reg <= cmd.st_code;
        end
        if (cmd.do_mul)
        begin
            prod_reg  <= 29'(item_reg.rec_index) * 29'(entry_size_reg);
            table_reg <= 29'(entry_count_reg) * 29'(entry_size_reg);
        end
        if (cmd.do_add)
        begin
            off_reg      <= AW'(off_sum);
            in_range_reg <= (off_end <= 31'(table_reg)) && (off_end <= 31'(STORE_BYTES));
        end
        if (cmd.rd_capture)
        begin
            rd_reg <= (item_reg.action == ACT_GET_BITS) ?
                      ((word & desc_rd.mask) >> desc_rd.shift) : word;
        end
        if (cmd.res_load)
        begin
            res_value_reg  <= rd_reg;
            res_status_reg <= st_reg;
        end
    end

    // descriptor table
    assign desc_wdata = '{key: item_reg.field_key, mask: item_reg.field_mask,
                          start: item_reg.field_start, shift: item_reg.field_shift};
    assign desc_rd = desc_t'(desc_rdata);

    rtba_ram #(.W($bits(desc_t)), .D(MAX_FIELDS)) u_desc (
        .clk   (clk),
        .we    (cmd.desc_add),
        .waddr (FW'(count_reg)),
        .wdata (desc_wdata),
        .re    (cmd.scan_rd),
        .raddr (FW'(scan_reg)),
        .rdata (desc_rdata)
    );

    // record store in four byte banks, bank = address mod 4
    assign boff_ext = 17'(item_reg.byte_offset);
    assign boff_a   = AW'(item_reg.byte_offset);

    always_comb
    begin
        logic [1:0] b;
        word = '0;
        for (int j = 0; j < 4; j++)
        begin
            b = off_reg[1:0] + 2'(j);
            word[31 - 8*j -: 8] = bank_rd[b];
        end
    end

    assign new_word = (item_reg.action == ACT_SET_BITS) ?
        ((word & ~desc_rd.mask) | ((item_reg.write_value << desc_rd.shift) & desc_rd.mask)) :
        item_reg.write_value;

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        logic [1:0]    j;
        logic [AW-1:0] addr;
        logic [RW-1:0] row;
        logic          we;
        logic [7:0]    wdata;

        assign j     = 2'(k) - off_reg[1:0];
        assign addr  = cmd.byte_load ? boff_a : off_reg + AW'(j);
        assign row   = RW'(addr >> 2);
        assign we    = cmd.store_wr || (cmd.byte_load && boff_a[1:0] == 2'(k));
        assign wdata = cmd.byte_load ? item_reg.byte_value : 8'(new_word >> (8 * (3 - j)));

        rtba_ram #(.W(8), .D(BD)) u_bank (
            .clk   (clk),
            .we    (we),
            .waddr (row),
            .wdata (wdata),
            .re    (cmd.store_rd),
            .raddr (row),
            .rdata (bank_rd[k])
        );
    end

    assign sts.action    = item_reg.action;
    assign sts.full      = count_reg >= CW'(MAX_FIELDS);
    assign sts.boff_ok   = boff_ext < 17'(STORE_BYTES);
    assign sts.scan_end  = scan_reg >= count_reg;
    assign sts.key_match = desc_rd.key == item_reg.field_key;
    assign sts.in_range  = in_range_reg;
    assign sts.res_busy  = res_valid_reg && !out_ready;

    assign out_valid  = res_valid_reg;
    assign read_value = res_value_reg;
    assign status     = res_status_reg;
endmodule

[rtl/record_table_bitfield_access_core.sv]
// record table with bit-field access
// in_ch carries one command item (add/clear descriptor, load byte, get/set
// bits, get/set word); out_ch returns one item per command: read_value and
// status. configuration (entry_count index 0, entry_size index 1) is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while the
// block is idle, the block itself does not enforce this. one item is worked
// at a time. add, clear, load and the unused action go from dispatch straight
// to the result. field accesses scan the descriptor table one entry at a time
// (registered ram read, then key compare), then multiply, add and range
// check, then one four-bank store access; a miss over all descriptors ends
// the scan with the nofield status.
// the store is four byte-wide rams, so any unaligned word is read or
// written with one access to all four banks.
// the result sits in an output register; a new item is accepted while it
// waits, and the block holds its next result until the receiver takes it.
// reset clears the state, configuration, descriptor count, scan index and
// output valid; store and descriptor contents are undefined until written.
module record_table_bitfield_access_core import rtba_pkg::*; #(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int MAX_FIELDS  = MAX_FIELDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rtba_in_if.sink     in_ch,
    rtba_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    item_t item;
    cmd_t  cmd;
    sts_t  sts;

    assign item = '{action: act_t'(in_ch.action), field_key: in_ch.field_key,
                    field_mask: in_ch.field_mask, field_start: in_ch.field_start,
                    field_shift: in_ch.field_shift, rec_index: in_ch.rec_index,
                    byte_offset: in_ch.byte_offset, byte_value: in_ch.byte_value,
                    write_value: in_ch.write_value};

    rtba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rtba_dp #(.STORE_BYTES(STORE_BYTES), .MAX_FIELDS(MAX_FIELDS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .read_value (out_ch.read_value),
        .status     (out_ch.status)
    );
endmodule

[rtl/rtba_chk.sv]
module rtba_chk import rtba_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] read_value,
    input logic [1:0]  status
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status))
        else $error("stalled result changed");

    // errors carry a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> read_value == 32'd0)
        else $error("nonzero value with error status");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted while busy");

    // a result does not rise straight after accept while no stalled result waits
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !(out_valid && !out_ready) |=> !$rose(out_valid))
        else $error("result too early");
endmodule

bind record_table_bitfield_access_core rtba_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .read_value (out_ch.read_value),
    .status     (out_ch.status)
);
